[rtl/core/wlsf_pkg.sv]
package wlsf_pkg;

    // Default sizes of the history and of the line length limit
    localparam int PATTERN_MAX_DEF = 16;
    localparam int MAX_LINE_DEF    = 65536;

    // Pattern storage is fixed by the register map: two 64-bit words
    localparam int PATTERN_BYTES = 16;
    localparam int PATTERN_W     = 8 * PATTERN_BYTES;
    localparam int PLEN_W        = 5;

    // Input opcodes
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_FILE = 2'd2;

    // Register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [2:0] REG_WINDOW_LEN   = 3'd3;
    localparam logic [2:0] REG_CASE_INSENS  = 3'd4;
    localparam logic [2:0] REG_INVERT       = 3'd5;

    // Character constants for case folding
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] FOLD_OFFSET  = 8'h20;

    // Pattern setup seen by the compare unit
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [PLEN_W-1:0]    length;
    } t_match_cfg;

endpackage

[rtl/core/windowed_line_substring_filter_core.sv]
// Line filter: takes one text word per cycle (data byte, end of line or new
// file) while o_in_stall is low, and gives one result word per end of line
// with the print decision, trigger mark, line number and distance from the
// first printed line of the file. An end-of-line word passes the input
// register and then loads the result register. While a result waits on
// i_out_stall, data and new-file words keep flowing and only the next
// end-of-line word holds in the input register. The substring compare is a
// parallel compare of the last PATTERN_MAX bytes against the pattern, so
// pattern length sets no cycle count. Configuration goes through the APB
// port at byte address 8*index; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module windowed_line_substring_filter_core #(
    parameter int PATTERN_MAX = wlsf_pkg::PATTERN_MAX_DEF,
    parameter int MAX_LINE    = wlsf_pkg::MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_print_line,
    output logic        o_trigger_line,
    output logic [31:0] o_line_number,
    output logic [31:0] o_relative_number,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Character counter holds up to MAX_LINE-1
    localparam int CNT_W = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;

    // ---------------- configuration registers ----------------
    logic [63:0] r_pattern_low;
    logic [63:0] r_pattern_high;
    logic [4:0]  r_pattern_len;
    logic [31:0] r_window_len;
    logic        r_case_insens;
    logic        r_invert;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Write on the access cycle; writes past the map drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_pattern_len  <= '0;
            r_window_len   <= '0;
            r_case_insens  <= 1'b1;
            r_invert       <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                wlsf_pkg::REG_PATTERN_LOW:  r_pattern_low  <= pwdata;
                wlsf_pkg::REG_PATTERN_HIGH: r_pattern_high <= pwdata;
                wlsf_pkg::REG_PATTERN_LEN:  r_pattern_len  <= pwdata[4:0];
                wlsf_pkg::REG_WINDOW_LEN:   r_window_len   <= pwdata[31:0];
                wlsf_pkg::REG_CASE_INSENS:  r_case_insens  <= pwdata[0];
                wlsf_pkg::REG_INVERT:       r_invert       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            wlsf_pkg::REG_PATTERN_LOW:  prdata = r_pattern_low;
            wlsf_pkg::REG_PATTERN_HIGH: prdata = r_pattern_high;
            wlsf_pkg::REG_PATTERN_LEN:  prdata = {59'd0, r_pattern_len};
            wlsf_pkg::REG_WINDOW_LEN:   prdata = {32'd0, r_window_len};
            wlsf_pkg::REG_CASE_INSENS:  prdata = {63'd0, r_case_insens};
            wlsf_pkg::REG_INVERT:       prdata = {63'd0, r_invert};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [1:0] r_in_opcode;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       proc_fire;
    logic       in_take;

    // An end-of-line word needs a free result slot; everything else moves on
    assign out_free   = !o_out_valid || !i_out_stall;
    assign proc_fire  = r_in_valid && ((r_in_opcode != wlsf_pkg::OP_EOL) || out_free);
    assign o_in_stall = r_in_valid && !proc_fire;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_opcode <= i_opcode;
            r_in_byte   <= i_data_byte;
        end
    end

    // ---------------- line state ----------------
    logic [PATTERN_MAX-1:0][7:0] r_hist, n_hist, shift_hist;
    logic [CNT_W-1:0]            r_chars, n_chars, chars_next;
    logic                        r_seen, n_seen;
    logic [31:0]                 r_line, n_line;
    logic [31:0]                 r_last_trig, n_last_trig;
    logic [31:0]                 r_first, n_first;
    logic                        r_first_valid, n_first_valid;

    logic [7:0]           fold_byte;
    logic                 drop_byte;
    logic                 hit;
    logic                 in_window;
    logic                 seen;
    logic                 trig;
    logic                 print;
    logic [31:0]          rel;
    wlsf_pkg::t_match_cfg match_cfg;

    // Fold A-Z to lowercase when enabled
    always_comb begin
        fold_byte = r_in_byte;
        if (r_case_insens && (r_in_byte >= wlsf_pkg::CHAR_UPPER_A)
                && (r_in_byte <= wlsf_pkg::CHAR_UPPER_Z)) begin
            fold_byte = r_in_byte + wlsf_pkg::FOLD_OFFSET;
        end
    end

    // History as it stands after taking this byte
    always_comb begin
        shift_hist[0] = fold_byte;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            shift_hist[i] = r_hist[i-1];
        end
    end

    assign chars_next = r_chars + CNT_W'(1);
    // Past the line length limit a byte neither shifts in nor counts
    assign drop_byte  = (32'(r_chars) >= 32'(MAX_LINE - 1));

    assign match_cfg.pattern = {r_pattern_high, r_pattern_low};
    assign match_cfg.length  = r_pattern_len;

    wlsf_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .CNT_W       (CNT_W)
    ) u_match (
        .i_cfg   (match_cfg),
        .i_hist  (shift_hist),
        .i_chars (chars_next),
        .o_hit   (hit)
    );

    // End-of-line decision. A stored trigger of zero means none, which also
    // covers a trigger on a wrapped line zero.
    always_comb begin
        in_window = (r_last_trig != 32'd0) && ((r_line - r_last_trig) < r_window_len);
        seen      = r_seen || (r_pattern_len == '0);
        trig      = !in_window && (seen != r_invert);
        print     = in_window || trig;
        rel       = '0;
        if (print && r_first_valid) begin
            rel = r_line - r_first;
        end
    end

    always_comb begin
        n_hist        = r_hist;
        n_chars       = r_chars;
        n_seen        = r_seen;
        n_line        = r_line;
        n_last_trig   = r_last_trig;
        n_first       = r_first;
        n_first_valid = r_first_valid;
        if (proc_fire) begin
            case (r_in_opcode)
                wlsf_pkg::OP_DATA: begin
                    if (!drop_byte) begin
                        n_hist  = shift_hist;
                        n_chars = chars_next;
                        if (hit) begin
                            n_seen = 1'b1;
                        end
                    end
                end
                wlsf_pkg::OP_EOL: begin
                    n_line = r_line + 32'd1;
                    if (trig) begin
                        n_last_trig = r_line;
                    end
                    if (print && !r_first_valid) begin
                        n_first_valid = 1'b1;
                        n_first       = r_line;
                    end
                    n_hist  = '0;
                    n_chars = '0;
                    n_seen  = 1'b0;
                end
                wlsf_pkg::OP_FILE: begin
                    // drop any partial line and restart numbering
                    n_hist        = '0;
                    n_chars       = '0;
                    n_seen        = 1'b0;
                    n_line        = 32'd1;
                    n_last_trig   = '0;
                    n_first       = '0;
                    n_first_valid = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist        <= '0;
            r_chars       <= '0;
            r_seen        <= 1'b0;
            r_line        <= 32'd1;
            r_last_trig   <= '0;
            r_first       <= '0;
            r_first_valid <= 1'b0;
        end else begin
            r_hist        <= n_hist;
            r_chars       <= n_chars;
            r_seen        <= n_seen;
            r_line        <= n_line;
            r_last_trig   <= n_last_trig;
            r_first       <= n_first;
            r_first_valid <= n_first_valid;
        end
    end

    // ---------------- result register ----------------
    logic        r_out_valid;
    logic        r_out_print;
    logic        r_out_trig;
    logic [31:0] r_out_line;
    logic [31:0] r_out_rel;
    logic        out_load;

    assign out_load = proc_fire && (r_in_opcode == wlsf_pkg::OP_EOL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Relative number is zero on the first printed line itself
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_print <= print;
            r_out_trig  <= trig;
            r_out_line  <= r_line;
            r_out_rel   <= rel;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_print_line      = r_out_print;
    assign o_trigger_line    = r_out_trig;
    assign o_line_number     = r_out_line;
    assign o_relative_number = r_out_rel;

endmodule

[rtl/core/wlsf_match.sv]
module wlsf_match #(
    parameter int PATTERN_MAX = wlsf_pkg::PATTERN_MAX_DEF,
    parameter int CNT_W       = 16
) (
    input  wlsf_pkg::t_match_cfg          i_cfg,
    input  logic [PATTERN_MAX-1:0][7:0]   i_hist,
    input  logic [CNT_W-1:0]              i_chars,
    output logic                          o_hit
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [LEN_W-1:0]       used_len;
    logic [IDX_W-1:0]       sel;
    logic [PATTERN_MAX-1:0] lane_ok;

    // Clamp the length to the history depth
    always_comb begin
        if (i_cfg.length > wlsf_pkg::PLEN_W'(PATTERN_MAX)) begin
            used_len = LEN_W'(PATTERN_MAX);
        end else begin
            used_len = LEN_W'(i_cfg.length);
        end
    end

    // Pattern byte i lines up with history entry used_len-1-i
    always_comb begin
        sel = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            lane_ok[i] = 1'b1;
            if (i < int'(used_len)) begin
                sel        = IDX_W'(int'(used_len) - 1 - i);
                lane_ok[i] = (i_hist[sel] == i_cfg.pattern[i*8 +: 8]);
            end
        end
    end

    assign o_hit = (&lane_ok) && (32'(i_chars) >= 32'(used_len));

endmodule

[rtl/core/wlsf_checker.sv]
module wlsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_print_line,
    input logic        o_trigger_line,
    input logic [31:0] o_line_number,
    input logic [31:0] o_relative_number
);

    // Hold a stalled result word unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_print_line)
            && $stable(o_trigger_line) && $stable(o_line_number)
            && $stable(o_relative_number))
        else $error("stalled result word changed");

    // A trigger line always prints
    a_trig_prints: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_trigger_line |-> o_print_line)
        else $error("trigger line without print");

    // Unprinted lines carry no relative number
    a_rel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_print_line |-> o_relative_number == 32'd0)
        else $error("relative number on unprinted line");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind windowed_line_substring_filter_core wlsf_checker u_wlsf_checker (.*);
